FILE: design/fcg_pkg.sv
package fcg_pkg;

	localparam int MAX_OUTPUTS = 16;
	localparam int MAX_INPUTS  = 256;

	localparam int ROW_AW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int COL_AW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int WDEPTH  = MAX_OUTPUTS * MAX_INPUTS;
	localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int ACC_W   = 34 + COL_AW;

	localparam logic [1:0] MODE_WEIGHT = 2'd0;
	localparam logic [1:0] MODE_BIAS   = 2'd1;
	localparam logic [1:0] MODE_INPUT  = 2'd2;

	localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd0;
	localparam logic [1:0] CFG_INPUT_COUNT  = 2'd1;
	localparam logic [1:0] CFG_USE_BIAS     = 2'd2;

	localparam logic [6:0]  OUTPUT_COUNT_RST = 7'd16;
	localparam logic [12:0] INPUT_COUNT_RST  = 13'd256;

	typedef struct packed {
		logic [1:0]         mode;
		logic [5:0]         row;
		logic [11:0]        column;
		logic signed [31:0] value;
		logic               start_req;
	} in_t;

	typedef struct packed {
		logic [5:0]         out_row;
		logic signed [31:0] out_value;
		logic               last;
	} out_t;

	typedef struct packed {
		logic               w_we;
		logic               x_we;
		logic               b_we;
		logic [WADDR_W-1:0] w_addr;
		logic [COL_AW-1:0]  x_addr;
		logic [ROW_AW-1:0]  b_addr;
		logic [31:0]        data;
	} wr_t;

	typedef struct packed {
		logic [WADDR_W-1:0] w_addr;
		logic [COL_AW-1:0]  x_addr;
		logic [ROW_AW-1:0]  b_addr;
	} rd_t;

endpackage

FILE: design/fully_connected_gemv.sv
// Fully connected layer as a matrix-vector product in fixed point. Requests load Q8.8 weights,
// Q16.16 row biases and Q8.8 input elements at one per cycle while in_stall is low; an input
// request with start_req set stores its element and then, if output_count is nonzero, starts a
// run that gives one saturated Q16.16 result per row, rows in order from 0, last set on the
// final row. A single multiply-accumulate walks the weight and input memories one column per
// cycle, and in_stall is held high for the whole run. The result register lets the next row
// compute while a result waits to be taken.
module fully_connected_gemv
	import fcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t             state_q;
	logic [6:0]         output_count_q;
	logic [12:0]        input_count_q;
	logic               use_bias_q;
	logic [ROW_AW-1:0]  r_q;
	logic [COL_AW-1:0]  c_q;
	logic               valid_s1;
	logic               wait_q;
	logic               out_valid_q;
	out_t               out_q;

	logic [6:0]         nout;
	logic [12:0]        nin;
	logic               in_acc;
	logic               start_go;
	logic               last_row;
	logic               load;
	logic               row_start;
	logic [ROW_AW-1:0]  next_row;
	logic               row_ok;
	logic               col_ok;
	wr_t                wr;
	rd_t                rd;
	logic signed [15:0] w_s1;
	logic signed [15:0] x_s1;
	logic signed [31:0] bias_q;
	logic               mac_busy;
	logic signed [31:0] result;

	assign nout = (output_count_q > 7'(MAX_OUTPUTS)) ? 7'(MAX_OUTPUTS) : output_count_q;
	assign nin  = (input_count_q > 13'(MAX_INPUTS)) ? 13'(MAX_INPUTS) : input_count_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign start_go = in_acc && (in_data.mode == MODE_INPUT) && in_data.start_req && (nout != 7'd0);

	assign row_ok = {1'b0, in_data.row} < 7'(MAX_OUTPUTS);
	assign col_ok = {1'b0, in_data.column} < 13'(MAX_INPUTS);

	always_comb begin
		wr.w_we   = in_acc && (in_data.mode == MODE_WEIGHT) && row_ok && col_ok;
		wr.b_we   = in_acc && (in_data.mode == MODE_BIAS) && row_ok;
		wr.x_we   = in_acc && (in_data.mode == MODE_INPUT) && col_ok;
		wr.w_addr = WADDR_W'(in_data.row[ROW_AW-1:0] * MAX_INPUTS + in_data.column[COL_AW-1:0]);
		wr.x_addr = in_data.column[COL_AW-1:0];
		wr.b_addr = in_data.row[ROW_AW-1:0];
		wr.data   = in_data.value;
	end

	always_comb begin
		rd.w_addr = WADDR_W'(r_q * MAX_INPUTS + c_q);
		rd.x_addr = c_q;
		rd.b_addr = r_q;
	end

	assign last_row  = (7'(r_q) + 7'd1) == nout;
	assign load      = (state_q == ST_DRAIN) && !valid_s1 && !mac_busy && !wait_q
		&& (!out_valid_q || !out_stall);
	assign row_start = start_go || (load && !last_row);
	assign next_row  = start_go ? '0 : ROW_AW'(r_q + 1'b1);

	fcg_store u_store (
		.clk    (clk),
		.wr     (wr),
		.rd     (rd),
		.w_s1   (w_s1),
		.x_s1   (x_s1),
		.bias_q (bias_q)
	);

	fcg_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.w_s1     (w_s1),
		.x_s1     (x_s1),
		.clear    (row_start),
		.use_bias (use_bias_q),
		.bias     (bias_q),
		.busy     (mac_busy),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_count_q <= OUTPUT_COUNT_RST;
			input_count_q  <= INPUT_COUNT_RST;
			use_bias_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OUTPUT_COUNT: output_count_q <= cfg_data[6:0];
				CFG_INPUT_COUNT:  input_count_q  <= cfg_data;
				CFG_USE_BIAS:     use_bias_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			valid_s1    <= 1'b0;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_READ);
			wait_q   <= row_start;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (row_start) begin
				r_q     <= next_row;
				c_q     <= '0;
				state_q <= (nin == 13'd0) ? ST_DRAIN : ST_READ;
			end else begin
				unique case (state_q)
					ST_IDLE: ;
					ST_READ: begin
						c_q <= COL_AW'(c_q + 1'b1);
						if ((13'(c_q) + 13'd1) == nin) begin
							state_q <= ST_DRAIN;
						end
					end
					ST_DRAIN: begin
						if (load) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_row   <= 6'(r_q);
			out_q.out_value <= result;
			out_q.last      <= last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: design/fcg_store.sv
module fcg_store
	import fcg_pkg::*;
(
	input  logic               clk,
	input  wr_t                wr,
	input  rd_t                rd,
	output logic signed [15:0] w_s1,
	output logic signed [15:0] x_s1,
	output logic signed [31:0] bias_q
);

	logic signed [15:0] weight_mem [WDEPTH];
	logic signed [15:0] input_mem  [MAX_INPUTS];
	logic signed [31:0] bias_mem   [MAX_OUTPUTS];

	always_ff @(posedge clk) begin
		if (wr.w_we) begin
			weight_mem[wr.w_addr] <= signed'(wr.data[15:0]);
		end
		w_s1 <= weight_mem[rd.w_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.x_we) begin
			input_mem[wr.x_addr] <= signed'(wr.data[15:0]);
		end
		x_s1 <= input_mem[rd.x_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.b_we) begin
			bias_mem[wr.b_addr] <= signed'(wr.data);
		end
		bias_q <= bias_mem[rd.b_addr];
	end

endmodule

FILE: design/fcg_mac.sv
module fcg_mac
	import fcg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  logic signed [15:0] w_s1,
	input  logic signed [15:0] x_s1,
	input  logic               clear,
	input  logic               use_bias,
	input  logic signed [31:0] bias,
	output logic               busy,
	output logic signed [31:0] result
);

	logic               valid_s2;
	logic signed [31:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] sum;
	logic [ACC_W-32:0]       upper;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_s1 * x_s1;
		if (clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_comb begin
		sum   = acc_q + (use_bias ? ACC_W'(bias) : ACC_W'(0));
		upper = sum[ACC_W-1:31];
		if ((&upper) || !(|upper)) begin
			result = sum[31:0];
		end else if (sum[ACC_W-1]) begin
			result = 32'sh8000_0000;
		end else begin
			result = 32'sh7fff_ffff;
		end
	end

	assign busy = valid_s2;

endmodule
